// ===== rtl/hss_pkg.sv =====
// Package with shared types, constants and a SHA-256 helper function for the HMAC signer.
package hss_pkg;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       end_of_msg;
    } in_item_t;

    typedef struct packed {
        logic [6:0] hex_char;
        logic       last_char;
    } out_item_t;

    localparam logic [1:0] REG_KEY_0 = 2'd0;
    localparam logic [1:0] REG_KEY_1 = 2'd1;
    localparam logic [1:0] REG_KEY_2 = 2'd2;
    localparam logic [1:0] REG_KEY_3 = 2'd3;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;
    localparam logic [3:0] NIB_MASK = 4'hf;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/hmac_sha256_hex_signer.sv =====
// Top level of the HMAC-SHA256 signer with a shared one-round-per-cycle compression unit.
//
// Usage: message bytes arrive on the input channel (in_data, in_valid, in_stall), one
// optional byte per transfer; end_of_msg marks the last transfer of a message. The key is
// written through cfg_we, cfg_addr and cfg_data while the block is idle.
// Each transfer with a byte stores it; every 64th byte adds one 64-round compression,
// run by the single round unit that performs one SHA-256 round per cycle.
// The first transfer of a message first folds in the inner key pad.
// The final transfer runs the padding blocks (one or two compressions), the outer pad and
// the outer block, then presents 64 hex characters on the output channel (out_data,
// out_valid, out_stall), one per transfer, last_char on the 64th.
// The input stalls while a byte is stored, padding is set up, a compression runs or characters remain to be sent.
// When the receiver stalls, the current character is held and nothing else advances.
// Reset clears the key to zero and returns the block to idle.
module hmac_sha256_hex_signer
    import hss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_data,
    input  in_item_t    in_data,
    input  logic        in_valid,
    output logic        in_stall,
    output out_item_t   out_data,
    output logic        out_valid,
    input  logic        out_stall
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ABS   = 4'd1;
    localparam logic [3:0] ST_LOAD  = 4'd2;
    localparam logic [3:0] ST_ROUND = 4'd3;
    localparam logic [3:0] ST_ADD   = 4'd4;
    localparam logic [3:0] ST_PAD   = 4'd5;
    localparam logic [3:0] ST_OUT   = 4'd6;
    localparam logic [3:0] ST_BYTE  = 4'd7;

    // What follows a compression.
    localparam logic [2:0] NX_ABS   = 3'd0;
    localparam logic [2:0] NX_PAD   = 3'd1;
    localparam logic [2:0] NX_LEN   = 3'd2;
    localparam logic [2:0] NX_OPAD  = 3'd3;
    localparam logic [2:0] NX_OUTER = 3'd4;
    localparam logic [2:0] NX_EMIT  = 3'd5;

    logic [3:0]  state_reg;
    logic [2:0]  nxt_reg;
    logic [63:0] key_reg [4];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] dig_reg [8];
    logic [63:0] cnt_reg;
    logic [5:0]  rnd_reg;
    logic [5:0]  idx_reg;
    logic        end_reg;
    logic [7:0]  byte_reg;

    logic [31:0] t1, t2, s0, s1, wnew;
    logic [63:0] bits;
    logic [31:0] word_sel;
    logic [3:0]  nib;

    assign in_stall = !(state_reg == ST_IDLE || state_reg == ST_ABS);
    assign out_valid = (state_reg == ST_OUT);
    assign bits = (cnt_reg + 64'd64) << 3;

    always_comb
    begin
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[rnd_reg] + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        word_sel = h_reg[idx_reg[5:3]];
        nib = word_sel[(5'd28 - {idx_reg[2:0], 2'b00}) +: 4] & NIB_MASK;
        out_data.hex_char = (nib < 4'd10) ? (7'd48 + {3'd0, nib}) : (7'd87 + {3'd0, nib});
        out_data.last_char = (idx_reg == 6'd63);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nxt_reg <= NX_ABS;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= IV[i];
                v_reg[i] <= '0;
                dig_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= '0;
            end
            cnt_reg <= '0;
            rnd_reg <= '0;
            idx_reg <= '0;
            end_reg <= 1'b0;
            byte_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                key_reg[cfg_addr] <= cfg_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            h_reg[i] <= IV[i];
                        end
                        for (int i = 0; i < 16; i++)
                        begin
                            w_reg[i] <= (i < 8) ? (key_reg[i / 2][(1 - i % 2) * 32 +: 32]
                                ^ {4{IPAD}}) : {4{IPAD}};
                        end
                        cnt_reg <= '0;
                        end_reg <= in_data.end_of_msg;
                        byte_reg <= in_data.msg_byte;
                        nxt_reg <= (in_data.has_byte || !in_data.end_of_msg) ? NX_ABS : NX_PAD;
                        if (in_data.has_byte)
                        begin
                            idx_reg <= 6'd1;
                        end
                        else
                        begin
                            idx_reg <= 6'd0;
                        end
                        state_reg <= ST_LOAD;
                    end
                end
                ST_ABS:
                begin
                    if (in_valid)
                    begin
                        end_reg <= in_data.end_of_msg;
                        byte_reg <= in_data.msg_byte;
                        if (in_data.has_byte)
                        begin
                            state_reg <= ST_BYTE;
                        end
                        else if (in_data.end_of_msg)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_BYTE:
                begin
                    // idx_reg tracks whether a byte is pending after a key compression.
                    w_reg[cnt_reg[5:2]][(2'd3 - cnt_reg[1:0]) * 8 +: 8] <= byte_reg;
                    cnt_reg <= cnt_reg + 64'd1;
                    idx_reg <= '0;
                    if (cnt_reg[5:0] == 6'd63)
                    begin
                        nxt_reg <= end_reg ? NX_PAD : NX_ABS;
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        state_reg <= end_reg ? ST_PAD : ST_ABS;
                    end
                end
                ST_PAD:
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            if (i * 4 + j == int'(cnt_reg[5:0]))
                            begin
                                w_reg[i][(3 - j) * 8 +: 8] <= 8'h80;
                            end
                            else if (i * 4 + j > int'(cnt_reg[5:0]))
                            begin
                                w_reg[i][(3 - j) * 8 +: 8] <= 8'h00;
                            end
                        end
                    end
                    if (cnt_reg[5:0] < 6'd56)
                    begin
                        w_reg[14] <= bits[63:32];
                        w_reg[15] <= bits[31:0];
                        nxt_reg <= NX_LEN;
                    end
                    else
                    begin
                        nxt_reg <= NX_OPAD;
                        end_reg <= 1'b0;
                    end
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                    rnd_reg <= '0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                    w_reg[15] <= wnew;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    case (nxt_reg)
                        NX_ABS:
                        begin
                            if (idx_reg[0])
                            begin
                                state_reg <= ST_BYTE;
                            end
                            else
                            begin
                                state_reg <= ST_ABS;
                            end
                        end
                        NX_PAD:
                        begin
                            state_reg <= ST_PAD;
                        end
                        NX_OPAD:
                        begin
                            // Second padding block: zeros and the length.
                            for (int i = 0; i < 14; i++)
                            begin
                                w_reg[i] <= '0;
                            end
                            w_reg[14] <= bits[63:32];
                            w_reg[15] <= bits[31:0];
                            nxt_reg <= NX_LEN;
                            state_reg <= ST_LOAD;
                        end
                        NX_LEN:
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                dig_reg[i] <= h_reg[i] + v_reg[i];
                                h_reg[i] <= IV[i];
                            end
                            for (int i = 0; i < 16; i++)
                            begin
                                w_reg[i] <= (i < 8) ? (key_reg[i / 2][(1 - i % 2) * 32 +: 32]
                                    ^ {4{OPAD}}) : {4{OPAD}};
                            end
                            nxt_reg <= NX_OUTER;
                            state_reg <= ST_LOAD;
                        end
                        NX_OUTER:
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                w_reg[i] <= dig_reg[i];
                            end
                            w_reg[8] <= 32'h80000000;
                            for (int i = 9; i < 15; i++)
                            begin
                                w_reg[i] <= '0;
                            end
                            w_reg[15] <= 32'd768;
                            nxt_reg <= NX_EMIT;
                            state_reg <= ST_LOAD;
                        end
                        default:
                        begin
                            idx_reg <= '0;
                            state_reg <= ST_OUT;
                        end
                    endcase
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        idx_reg <= idx_reg + 6'd1;
                        if (idx_reg == 6'd63)
                        begin
                            cnt_reg <= '0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the HMAC-SHA256 hex signer, with its own SHA-256 predictor.
`timescale 1ns / 100ps

module tb_top
    import hss_pkg::*;
();

    typedef logic [7:0][31:0]  chain_t;
    typedef logic [15:0][31:0] block_t;

    localparam int CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [63:0] cfg_data;
    in_item_t    in_data;
    logic        in_valid;
    logic        in_stall;
    out_item_t   out_data;
    logic        out_valid;
    logic        out_stall;

    in_item_t    pending_bytes[$];
    out_item_t   expected_chars[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          cycles;

    logic [63:0] key_words[4];
    chain_t      chain;
    block_t      msg_block;
    logic [63:0] msg_len;
    logic        absorbing;

    hmac_sha256_hex_signer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic chain_t sha_compress(chain_t h, block_t blk);
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] s0, s1, t1, t2;
        chain_t      r;
        for (int t = 0; t < 16; t++)
            w[t] = blk[t];
        for (int t = 16; t < 64; t++)
        begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int t = 0; t < 8; t++)
            v[t] = h[t];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++)
            r[t] = h[t] + v[t];
        return r;
    endfunction

    function automatic chain_t keyed_start(logic [7:0] pad);
        block_t      blk;
        chain_t      iv_chain;
        logic [7:0]  kb;
        for (int i = 0; i < 64; i++)
        begin
            kb = (i < 32) ? key_words[i >> 3][63 - 8 * (i & 7) -: 8] : 8'h00;
            blk[i >> 2][31 - 8 * (i & 3) -: 8] = kb ^ pad;
        end
        for (int i = 0; i < 8; i++)
            iv_chain[i] = IV[i];
        return sha_compress(iv_chain, blk);
    endfunction

    task automatic sign_transfer(in_item_t item);
        chain_t      outer;
        block_t      ob;
        logic [63:0] bits;
        logic [7:0]  v;
        logic [3:0]  nib;
        int          idx;
        out_item_t   oc;
        if (!absorbing)
        begin
            chain = keyed_start(IPAD);
            msg_len = '0;
            absorbing = 1'b1;
        end
        if (item.has_byte)
        begin
            msg_block[msg_len[5:2]][31 - 8 * msg_len[1:0] -: 8] = item.msg_byte;
            msg_len = msg_len + 1;
            if (msg_len[5:0] == 6'd0)
                chain = sha_compress(chain, msg_block);
        end
        if (item.end_of_msg)
        begin
            idx = msg_len[5:0];
            bits = (msg_len + 64) << 3;
            msg_block[idx >> 2][31 - 8 * (idx & 3) -: 8] = 8'h80;
            idx++;
            if (idx > 56)
            begin
                while (idx < 64)
                begin
                    msg_block[idx >> 2][31 - 8 * (idx & 3) -: 8] = 8'h00;
                    idx++;
                end
                chain = sha_compress(chain, msg_block);
                idx = 0;
            end
            while (idx < 56)
            begin
                msg_block[idx >> 2][31 - 8 * (idx & 3) -: 8] = 8'h00;
                idx++;
            end
            msg_block[14] = bits[63:32];
            msg_block[15] = bits[31:0];
            chain = sha_compress(chain, msg_block);
            outer = keyed_start(OPAD);
            ob = '0;
            for (int i = 0; i < 8; i++)
                ob[i] = chain[i];
            ob[8] = 32'h80000000;
            ob[15] = 32'd768;
            outer = sha_compress(outer, ob);
            for (int k = 0; k < 64; k++)
            begin
                v = outer[k >> 3][31 - 8 * ((k >> 1) & 3) -: 8];
                nib = (k & 1) ? v[3:0] : v[7:4];
                oc.hex_char = (nib < 10) ? 7'(48 + nib) : 7'(87 + nib);
                oc.last_char = (k == 63);
                expected_chars.push_back(oc);
            end
            msg_len = '0;
            absorbing = 1'b0;
        end
    endtask

    task automatic report_mismatch(string what, int exp_v, int got_v);
        $display("error at cycle %0d: %s expected %0d got %0d", cycles, what, exp_v, got_v);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                sign_transfer(in_data);
                void'(pending_bytes.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_bytes[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch("unexpected character", -1, out_data.hex_char);
                else
                begin
                    if (out_data.hex_char !== expected_chars[0].hex_char)
                        report_mismatch("hex_char", expected_chars[0].hex_char,
                                        out_data.hex_char);
                    if (out_data.last_char !== expected_chars[0].last_char)
                        report_mismatch("last_char", expected_chars[0].last_char,
                                        out_data.last_char);
                    void'(expected_chars.pop_front());
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic add_item(logic [7:0] b, logic has, logic last);
        in_item_t it;
        it.msg_byte = b;
        it.has_byte = has;
        it.end_of_msg = last;
        pending_bytes.push_back(it);
    endtask

    // A message of len bytes with occasional empty transfers mixed in.
    task automatic add_message(int len, ref int count);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                add_item(8'($urandom), 1'b0, 1'b0);
                count++;
            end
            add_item(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(1));
            count++;
        end
        if (len == 0 || !pending_bytes[$].end_of_msg)
        begin
            add_item(8'($urandom), 1'b0, 1'b1);
            count++;
        end
    endtask

    task automatic settle_and_key(logic [63:0] k0, logic [63:0] k1,
                                  logic [63:0] k2, logic [63:0] k3);
        wait (pending_bytes.size() == 0 && expected_chars.size() == 0);
        repeat (400) @(posedge clk);
        key_words[0] = k0;
        key_words[1] = k1;
        key_words[2] = k2;
        key_words[3] = k3;
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_we   <= 1'b1;
            cfg_addr <= 2'(i);
            cfg_data <= key_words[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int count;
        int len;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_KEY_0;
        cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        absorbing = 1'b0;
        msg_len = '0;
        chain = '0;
        msg_block = '0;
        for (int i = 0; i < 4; i++)
            key_words[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        settle_and_key('0, '0, '0, '0);

        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'hff, 1'b1, 1'b0);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'h80, 1'b1, 1'b1);
        add_item(8'h01, 1'b1, 1'b1);
        add_item(8'hff, 1'b0, 1'b1);
        for (int i = 0; i < 3; i++)
            add_item(8'(8'h61 + i), 1'b1, i == 2);
        settle_and_key('1, '1, '1, '1);
        add_item(8'hff, 1'b1, 1'b1);
        add_item(8'h00, 1'b0, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            if (ph == 1)
                settle_and_key({$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom});
            else if (ph == 3)
                settle_and_key({$urandom, $urandom}, '0, '1, {$urandom, $urandom});
            count = 0;
            while (count < 62)
            begin
                case ($urandom_range(9))
                    0: len = 55 + $urandom_range(1);
                    1: len = 63 + $urandom_range(2);
                    default: len = $urandom_range(12);
                endcase
                if ($urandom_range(19) == 0)
                begin
                    add_item(8'($urandom), 1'($urandom_range(1)), 1'b0);
                    count++;
                end
                add_message(len, count);
            end
        end

        wait (pending_bytes.size() == 0 && expected_chars.size() == 0);
        repeat (400) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
